### rtl/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int ID_BITS    = 8;
  localparam int TIME_BITS  = 16;
  localparam int ADDR_BITS  = $clog2(HEAP_DEPTH + 1);
  localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_QUEUED    = 3'd0,
    EV_PREEMPTED = 3'd1,
    EV_DROPPED   = 3'd2,
    EV_IDLE      = 3'd3,
    EV_RAN       = 3'd4,
    EV_COMPLETED = 3'd5
  } event_t;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                 command;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] burst_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           event_res;
    logic [ID_BITS-1:0]   current_id;
    logic [TIME_BITS-1:0] remaining;
    logic [ID_BITS-1:0]   displaced_id;
    logic [6:0]           waiting_count;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] left;
  } slot_t;

  // Heap operation handed from the front to the heap engine.
  typedef enum logic [1:0] {
    HOP_NONE = 2'd0,
    HOP_PUSH = 2'd1,
    HOP_POP  = 2'd2
  } hop_t;

  typedef struct packed {
    hop_t      op;
    slot_t     slot;
    out_item_t res;
  } job_t;

  typedef enum logic [2:0] {
    HS_IDLE  = 3'd0,
    HS_UPRD  = 3'd1,
    HS_UPCMP = 3'd2,
    HS_DNRD  = 3'd3,
    HS_DNCMP = 3'd4,
    HS_DONE  = 3'd5
  } hstate_t;

endpackage
`default_nettype wire

### rtl/srt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: holds the running task and classifies each command.
module srt_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire srt_pkg::in_item_t item,
  input  wire logic              pop_done,
  input  wire srt_pkg::slot_t    pop_slot,
  output srt_pkg::job_t          job,
  output logic                   job_valid
);

  logic                            run_v_r, run_v_nxt;
  logic [srt_pkg::ID_BITS-1:0]     run_id_r, run_id_nxt;
  logic [srt_pkg::TIME_BITS-1:0]   run_left_r, run_left_nxt;
  logic [srt_pkg::CNT_BITS-1:0]    size_r, size_nxt;
  logic                            wait_pop_r, wait_pop_nxt;
  srt_pkg::job_t                   job_nxt;
  logic                            jv_nxt;
  logic [srt_pkg::TIME_BITS-1:0]   dec;
  srt_pkg::slot_t                  cur;

  // Tick step applied to a running slot.
  always_comb begin
    cur = pop_done ? pop_slot : srt_pkg::slot_t'{id: run_id_r, left: run_left_r};
    dec = (cur.left != '0) ? cur.left - 1'b1 : '0;
  end

  always_comb begin
    run_v_nxt    = run_v_r;
    run_id_nxt   = run_id_r;
    run_left_nxt = run_left_r;
    size_nxt     = size_r;
    wait_pop_nxt = wait_pop_r;
    job_nxt      = '0;
    jv_nxt       = 1'b0;
    if (take) begin
      if (item.command == srt_pkg::CMD_ARRIVAL) begin
        jv_nxt = 1'b1;
        if (size_r >= srt_pkg::CNT_BITS'(srt_pkg::HEAP_DEPTH)) begin
          job_nxt.op                = srt_pkg::HOP_NONE;
          job_nxt.res.event_res     = srt_pkg::EV_DROPPED;
          job_nxt.res.current_id    = item.task_id;
          job_nxt.res.remaining     = item.burst_len;
        end else if (run_v_r && item.burst_len < run_left_r) begin
          job_nxt.op                = srt_pkg::HOP_PUSH;
          job_nxt.slot              = '{id: run_id_r, left: run_left_r};
          job_nxt.res.event_res     = srt_pkg::EV_PREEMPTED;
          job_nxt.res.current_id    = item.task_id;
          job_nxt.res.remaining     = item.burst_len;
          job_nxt.res.displaced_id  = run_id_r;
          run_id_nxt   = item.task_id;
          run_left_nxt = item.burst_len;
          size_nxt     = size_r + 1'b1;
        end else begin
          job_nxt.op                = srt_pkg::HOP_PUSH;
          job_nxt.slot              = '{id: item.task_id, left: item.burst_len};
          job_nxt.res.event_res     = srt_pkg::EV_QUEUED;
          job_nxt.res.current_id    = run_v_r ? run_id_r : '0;
          job_nxt.res.remaining     = run_v_r ? run_left_r : '0;
          size_nxt     = size_r + 1'b1;
        end
      end else if (!run_v_r && size_r != '0) begin
        // Pop needed: the engine returns the top later.
        jv_nxt       = 1'b1;
        job_nxt.op   = srt_pkg::HOP_POP;
        size_nxt     = size_r - 1'b1;
        wait_pop_nxt = 1'b1;
      end else if (!run_v_r) begin
        jv_nxt = 1'b1;
        job_nxt.res.event_res = srt_pkg::EV_IDLE;
      end else begin
        jv_nxt = 1'b1;
        job_nxt.res.current_id = run_id_r;
        job_nxt.res.remaining  = dec;
        job_nxt.res.event_res  = (dec == '0) ? srt_pkg::EV_COMPLETED : srt_pkg::EV_RAN;
        run_left_nxt = dec;
        if (dec == '0) begin
          run_v_nxt  = 1'b0;
          run_id_nxt = '0;
        end else begin
          run_v_nxt = 1'b1;
        end
      end
      job_nxt.res.waiting_count = 7'(size_nxt);
    end
    // Popped task arrives: finish the tick on it, result is built in the output register.
    if (pop_done) begin
      run_left_nxt = dec;
      run_v_nxt    = (dec != '0);
      run_id_nxt   = (dec != '0) ? pop_slot.id : '0;
      wait_pop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_v_r    <= 1'b0;
      run_id_r   <= '0;
      run_left_r <= '0;
      size_r     <= '0;
      wait_pop_r <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      run_v_r    <= run_v_nxt;
      run_id_r   <= run_id_nxt;
      run_left_r <= run_left_nxt;
      size_r     <= size_nxt;
      wait_pop_r <= wait_pop_nxt;
      job_valid  <= jv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_nxt;
  end

endmodule
`default_nettype wire

### rtl/srt_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// Heap engine: one-entry job queue, then sift-up or sift-down over memory.
module srt_heap (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  input  wire srt_pkg::job_t    job,
  output logic                  busy,
  output logic                  pop_done,
  output srt_pkg::slot_t        pop_slot,
  output logic                  res_valid,
  output srt_pkg::out_item_t    res
);

  localparam int AW = srt_pkg::ADDR_BITS;

  srt_pkg::slot_t mem [1:srt_pkg::HEAP_DEPTH];

  srt_pkg::hstate_t state_r, state_nxt;
  logic                         q_v_r;
  srt_pkg::job_t                q_r;
  logic [AW-1:0]                cur_r, cur_nxt;
  logic [AW-1:0]                size_r, size_nxt;
  srt_pkg::slot_t               key_r, key_nxt;
  srt_pkg::slot_t               rd_a_r, rd_b_r;
  logic [AW-1:0]                ra, rb;
  logic                         we;
  logic [AW-1:0]                wa;
  srt_pkg::slot_t               wd;
  logic                         start_job;
  logic [AW:0]                  lc;
  logic                         has_r;
  srt_pkg::slot_t               child;
  logic [AW-1:0]                child_a;
  logic                         res_v_nxt;
  logic                         pop_nxt;
  srt_pkg::slot_t               top_r;
  logic                         pop_first_r;

  assign busy      = q_v_r || (state_r != srt_pkg::HS_IDLE);
  assign start_job = q_v_r && (state_r == srt_pkg::HS_IDLE);
  assign lc        = {cur_r, 1'b0};

  // Next state; key_r carries the moving entry, cur_r its hole.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    size_nxt  = size_r;
    key_nxt   = key_r;
    has_r     = (lc + 1'b1) <= {1'b0, size_r};
    child     = (has_r && rd_a_r.left > rd_b_r.left) ? rd_b_r : rd_a_r;
    child_a   = (has_r && rd_a_r.left > rd_b_r.left) ? AW'(lc + 1'b1) : AW'(lc);
    case (state_r)
      srt_pkg::HS_IDLE: begin
        if (start_job) begin
          case (q_r.op)
            srt_pkg::HOP_PUSH: begin
              size_nxt  = size_r + 1'b1;
              cur_nxt   = size_r + 1'b1;
              key_nxt   = q_r.slot;
              state_nxt = srt_pkg::HS_UPRD;
            end
            srt_pkg::HOP_POP: begin
              size_nxt  = size_r - 1'b1;
              cur_nxt   = AW'(1);
              state_nxt = srt_pkg::HS_DNRD;
            end
            default: state_nxt = srt_pkg::HS_DONE;
          endcase
        end
      end
      srt_pkg::HS_UPRD: begin
        if (cur_r > AW'(1)) state_nxt = srt_pkg::HS_UPCMP;
        else state_nxt = srt_pkg::HS_DONE;
      end
      srt_pkg::HS_UPCMP: begin
        if (rd_a_r.left > key_r.left) begin
          cur_nxt   = cur_r >> 1;
          state_nxt = srt_pkg::HS_UPRD;
        end else begin
          state_nxt = srt_pkg::HS_DONE;
        end
      end
      srt_pkg::HS_DNRD: begin
        if (lc <= {1'b0, size_r}) state_nxt = srt_pkg::HS_DNCMP;
        else state_nxt = srt_pkg::HS_DONE;
      end
      srt_pkg::HS_DNCMP: begin
        if (key_r.left < child.left) begin
          state_nxt = srt_pkg::HS_DONE;
        end else begin
          cur_nxt   = child_a;
          state_nxt = srt_pkg::HS_DNRD;
        end
      end
      srt_pkg::HS_DONE: state_nxt = srt_pkg::HS_IDLE;
      default:          state_nxt = srt_pkg::HS_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    we        = 1'b0;
    wa        = cur_r;
    wd        = key_r;
    ra        = cur_r >> 1;
    rb        = AW'(lc + 1'b1);
    res_v_nxt = 1'b0;
    pop_nxt   = 1'b0;
    case (state_r)
      srt_pkg::HS_IDLE: begin
        ra = AW'(1);
        rb = size_r;
      end
      srt_pkg::HS_UPRD: begin
        we = 1'b1;
        ra = cur_r >> 1;
      end
      srt_pkg::HS_UPCMP: begin
        if (rd_a_r.left > key_r.left) begin
          we = 1'b1;
          wd = rd_a_r;
        end
      end
      srt_pkg::HS_DNRD: begin
        // On the first level the last entry is still in the read register.
        we = 1'b1;
        wd = pop_first_r ? rd_b_r : key_r;
        ra = AW'(lc);
        rb = AW'(lc + 1'b1);
      end
      srt_pkg::HS_DNCMP: begin
        if (!(key_r.left < child.left)) begin
          we = 1'b1;
          wd = child;
        end
      end
      srt_pkg::HS_DONE: begin
        res_v_nxt = 1'b1;
        pop_nxt   = (q_r.op == srt_pkg::HOP_POP);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // Pop: capture the top and the last entry on the first read cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::HS_IDLE;
      q_v_r       <= 1'b0;
      size_r      <= '0;
      res_valid   <= 1'b0;
      pop_done    <= 1'b0;
      pop_first_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      res_valid   <= res_v_nxt && (q_r.op != srt_pkg::HOP_POP);
      pop_done    <= pop_nxt;
      pop_first_r <= start_job && (q_r.op == srt_pkg::HOP_POP);
      if (job_valid) q_v_r <= 1'b1;
      else if (state_r == srt_pkg::HS_DONE) q_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (job_valid) q_r <= job;
    if (pop_first_r) begin
      top_r <= rd_a_r;
      key_r <= rd_b_r;
    end else begin
      key_r <= key_nxt;
    end
    res <= q_r.res;
  end

  assign pop_slot = top_r;

endmodule
`default_nettype wire

### rtl/srt_out.sv
`timescale 1ns / 1ps
`default_nettype none
// Result register: merges direct results with those finished after a pop.
module srt_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire srt_pkg::out_item_t res,
  input  wire logic              pop_done,
  input  wire srt_pkg::slot_t    pop_slot,
  input  wire logic [6:0]        pop_count,
  output logic                   out_valid,
  output srt_pkg::out_item_t     out_item
);

  srt_pkg::out_item_t            item_nxt;
  logic [srt_pkg::TIME_BITS-1:0] dec;

  always_comb begin
    dec      = (pop_slot.left != '0) ? pop_slot.left - 1'b1 : '0;
    item_nxt = res;
    if (pop_done) begin
      item_nxt               = '0;
      item_nxt.current_id    = pop_slot.id;
      item_nxt.remaining     = dec;
      item_nxt.event_res     = (dec == '0) ? srt_pkg::EV_COMPLETED : srt_pkg::EV_RAN;
      item_nxt.waiting_count = pop_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= res_valid || pop_done;
  end

  always_ff @(posedge clk) begin
    out_item <= item_nxt;
  end

endmodule
`default_nettype wire

### rtl/shortest_remaining_time_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                              Transfer
// input     start, busy, in_item               start high while busy low
// result    out_valid, out_item                out_valid high, one cycle
// Drops and ticks without a pop skip the heap walk. Pushing arrivals sift up
// through HS_UPRD and HS_UPCMP for each heap level; popping ticks sift down
// through HS_DNRD and HS_DNCMP for each level.
// Reset is synchronous and active low; the heap memory is not cleared.
// Busy stays high from a transfer until its result is issued; the receiver
// cannot stall the block.
module shortest_remaining_time_scheduler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire srt_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output srt_pkg::out_item_t      out_item
);

  logic               take;
  srt_pkg::job_t      job;
  logic               job_valid;
  logic               heap_busy;
  logic               pop_done;
  srt_pkg::slot_t     pop_slot;
  logic               res_valid;
  srt_pkg::out_item_t res;
  logic               pend_r;
  logic [6:0]         cnt_r;

  assign take = start && !busy;
  assign busy = pend_r;

  // One item in flight until its result leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else if (take) pend_r <= 1'b1;
    else if (out_valid) pend_r <= 1'b0;
  end

  // Heap count after the step, kept for results that follow a pop.
  always_ff @(posedge clk) begin
    if (job_valid) cnt_r <= job.res.waiting_count;
  end

  srt_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .item(in_item),
    .pop_done(pop_done), .pop_slot(pop_slot), .job(job), .job_valid(job_valid)
  );

  srt_heap u_heap (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job), .busy(heap_busy),
    .pop_done(pop_done), .pop_slot(pop_slot), .res_valid(res_valid), .res(res)
  );

  srt_out u_out (
    .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res(res),
    .pop_done(pop_done), .pop_slot(pop_slot), .pop_count(heap_busy ? cnt_r : cnt_r),
    .out_valid(out_valid), .out_item(out_item)
  );

endmodule
`default_nettype wire
